/* hw/rtl/drpm_pkg.sv */
// Shared types, codes and rectangle helpers for the dirty rectangle pile manager.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package drpm_pkg;

   localparam logic [12:0] MAX_DIM = 13'd4096;

   typedef enum logic [1:0] {
      OP_INVALIDATE = 2'd0,
      OP_RECORD     = 2'd1,
      OP_READ       = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_APPENDED = 2'd0,
      ST_PENDING  = 2'd1,
      ST_IGNORED  = 2'd2,
      ST_DONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_LAYER_WIDTH   = 2'd0,
      CSR_LAYER_HEIGHT  = 2'd1,
      CSR_BUFFER_MARGIN = 2'd2,
      CSR_NONE          = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic        rec;
   } box_type;

   typedef struct packed {
      logic [12:0] lay_w;
      logic [12:0] lay_h;
      logic [3:0]  margin;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] rect_x;
      logic [11:0] rect_y;
      logic [12:0] rect_w;
      logic [12:0] rect_h;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  entry_count;
      box_type     ent;
      logic        whole_layer;
   } rsp_type;

   function automatic logic [13:0] box_right(box_type b);
      return {2'b00, b.x} + {1'b0, b.w};
   endfunction

   function automatic logic [13:0] box_bottom(box_type b);
      return {2'b00, b.y} + {1'b0, b.h};
   endfunction

   // True when a fully contains b.
   function automatic logic box_contains(box_type a, box_type b);
      return (b.x >= a.x) && (box_right(b) <= box_right(a)) &&
             (b.y >= a.y) && (box_bottom(b) <= box_bottom(a));
   endfunction

   function automatic logic box_meets(box_type a, box_type b);
      logic nonempty;
      nonempty = (a.w != '0) && (a.h != '0) && (b.w != '0) && (b.h != '0);
      return nonempty && !(({2'b00, b.x} >= box_right(a)) || (box_right(b) <= {2'b00, a.x}) ||
                           ({2'b00, b.y} >= box_bottom(a)) || (box_bottom(b) <= {2'b00, a.y}));
   endfunction

   function automatic box_type box_union(box_type a, box_type b);
      box_type     r;
      logic [13:0] rr;
      logic [13:0] bb;
      r.x = (a.x < b.x) ? a.x : b.x;
      r.y = (a.y < b.y) ? a.y : b.y;
      rr  = (box_right(a) > box_right(b)) ? box_right(a) : box_right(b);
      bb  = (box_bottom(a) > box_bottom(b)) ? box_bottom(a) : box_bottom(b);
      r.w = 13'(rr - {2'b00, r.x});
      r.h = 13'(bb - {2'b00, r.y});
      r.rec = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/drpm_entry_ram.sv */
// Entry store of the pile manager: one write port, one registered read port.
// Depends on drpm_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none
module drpm_entry_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output drpm_pkg::box_type rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  drpm_pkg::box_type wr_data
);
   import drpm_pkg::*;

   box_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/drpm_ctrl.sv */
// Sequencer of the pile manager: clipping, scan, area test, compaction, append and entry read.
// Depends on drpm_pkg and drives the entry store of drpm_entry_ram.
`timescale 1ns / 1ps
`default_nettype none
module drpm_ctrl #(
   parameter int MAX_ENTRIES = 16,
   parameter int IW          = 4,
   parameter int CW          = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  drpm_pkg::cfg_type cfg,
   input  logic              cfg_clear,
   input  logic              req_valid,
   output logic              req_stall,
   input  drpm_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output drpm_pkg::rsp_type rsp,
   output logic              mem_rd_en,
   output logic [IW-1:0]     mem_rd_addr,
   input  drpm_pkg::box_type mem_rd_data,
   output logic              mem_wr_en,
   output logic [IW-1:0]     mem_wr_addr,
   output drpm_pkg::box_type mem_wr_data
);
   import drpm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLIP, S_SCAN, S_SELECT, S_AREA_A, S_AREA_L, S_AREA_CMP,
      S_SWEEP, S_APPEND, S_READ, S_DONE
   } state_type;

   state_type   state_ff;
   req_type     in_ff;
   box_type     r_ff;
   box_type     mg_ff;
   box_type     res_ff;
   logic [1:0]  ovl_ff;
   logic        whole_ff;
   logic        mark_ff;
   status_type  status_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] rd_i_ff;
   logic [CW-1:0] pend_idx_ff;
   logic          pend_ff;
   logic [CW-1:0] wr_k_ff;
   logic [25:0]   area_ff;
   logic [25:0]   larea_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   box_type       lay;
   box_type       lay_rec;
   box_type       clip;
   box_type       ent;
   box_type       sweep_data;
   logic          accept;
   logic          idx_ok;
   logic          hit_pending;
   logic          hit_meet;
   logic          last;
   logic          keep;
   logic          full;
   logic          big;
   logic [12:0]   mul_a;
   logic [12:0]   mul_b;
   logic [25:0]   product;
   logic signed [15:0] cx0, cx1, cy0, cy1, cl, cr, ct, cb, cw, ch, lw_s, lh_s, m_s;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign lay     = '{x: 12'd0, y: 12'd0, w: cfg.lay_w, h: cfg.lay_h, rec: 1'b0};
   assign lay_rec = '{x: 12'd0, y: 12'd0, w: cfg.lay_w, h: cfg.lay_h, rec: 1'b1};
   assign idx_ok  = {{CW{1'b0}}, req.entry_index} < {4'b0000, count_ff};

   always_comb begin
      lw_s = $signed({3'b000, cfg.lay_w});
      lh_s = $signed({3'b000, cfg.lay_h});
      m_s  = $signed({12'd0, cfg.margin});
      cx0  = $signed({4'd0, in_ff.rect_x}) - m_s;
      cy0  = $signed({4'd0, in_ff.rect_y}) - m_s;
      cx1  = $signed({4'd0, in_ff.rect_x}) + $signed({3'd0, in_ff.rect_w}) + m_s;
      cy1  = $signed({4'd0, in_ff.rect_y}) + $signed({3'd0, in_ff.rect_h}) + m_s;
      cl   = (cx0 > 16'sd0) ? cx0 : 16'sd0;
      ct   = (cy0 > 16'sd0) ? cy0 : 16'sd0;
      cr   = (cx1 < lw_s) ? cx1 : lw_s;
      cb   = (cy1 < lh_s) ? cy1 : lh_s;
      cw   = cr - cl;
      ch   = cb - ct;
      if ((cr <= cl) || (cb <= ct)) begin
         clip = '0;
      end else begin
         clip = '{x: cl[11:0], y: ct[11:0], w: cw[12:0], h: ch[12:0], rec: 1'b0};
      end
   end

   assign ent         = mem_rd_data;
   assign hit_pending = !ent.rec && box_contains(ent, r_ff);
   assign hit_meet    = (pend_idx_ff != '0) && box_meets(ent, r_ff);
   assign last        = (pend_idx_ff + CW'(1)) == count_ff;
   assign keep        = mark_ff || !box_contains(r_ff, ent);
   assign full        = (wr_k_ff == CW'(MAX_ENTRIES));
   assign big         = ({1'b0, area_ff, 3'b000} + {3'b000, area_ff, 1'b0}) >
                        ({2'b00, larea_ff, 2'b00} + {3'b000, larea_ff, 1'b0} +
                         {4'b0000, larea_ff});

   always_comb begin
      sweep_data     = ent;
      sweep_data.rec = ent.rec | mark_ff;
   end

   assign mul_a   = (state_ff == S_AREA_A) ? r_ff.w : cfg.lay_w;
   assign mul_b   = (state_ff == S_AREA_A) ? r_ff.h : cfg.lay_h;
   assign product = mul_a * mul_b;

   always_comb begin
      count_in = count_ff;
      if (cfg_clear) begin
         count_in = '0;
      end else if (accept && (req.op == OP_RECORD) && (count_ff == '0)) begin
         count_in = CW'(1);
      end else if (state_ff == S_APPEND) begin
         count_in = full ? CW'(1) : wr_k_ff + CW'(1);
      end
   end

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_i_ff[IW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_k_ff[IW-1:0];
      mem_wr_data = sweep_data;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req.op == OP_READ) && idx_ok) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(req.entry_index);
            end
            if (accept && (req.op == OP_RECORD) && (count_ff == '0)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = lay_rec;
            end
         end
         S_SCAN: begin
            mem_rd_en = (rd_i_ff < count_ff) && !(pend_ff && hit_pending);
         end
         S_SWEEP: begin
            mem_rd_en = (rd_i_ff < count_ff);
            mem_wr_en = pend_ff && keep;
         end
         S_APPEND: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = full ? '0 : wr_k_ff[IW-1:0];
            mem_wr_data = full ? lay : r_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         pend_ff     <= mem_rd_en && ((state_ff == S_SCAN) || (state_ff == S_SWEEP));
         pend_idx_ff <= rd_i_ff;
         if (mem_rd_en && ((state_ff == S_SCAN) || (state_ff == S_SWEEP))) begin
            rd_i_ff <= rd_i_ff + CW'(1);
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  in_ff     <= req;
                  res_ff    <= '0;
                  whole_ff  <= 1'b0;
                  mark_ff   <= (req.op == OP_RECORD) && (count_ff != '0);
                  ovl_ff    <= 2'd0;
                  rd_i_ff   <= '0;
                  wr_k_ff   <= '0;
                  status_ff <= (req.op == OP_RECORD) ? ST_DONE : ST_IGNORED;
                  case (req.op)
                     OP_INVALIDATE: begin
                        if ((count_ff != '0) && (req.rect_w != '0) && (req.rect_h != '0)) begin
                           state_ff <= S_CLIP;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                     OP_RECORD: begin
                        state_ff <= (count_ff == '0) ? S_DONE : S_SWEEP;
                     end
                     OP_READ: begin
                        state_ff <= idx_ok ? S_READ : S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_CLIP: begin
               r_ff      <= clip;
               mg_ff     <= clip;
               status_ff <= ST_APPENDED;
               state_ff  <= S_SCAN;
            end
            S_SCAN: begin
               if (pend_ff) begin
                  if (hit_pending) begin
                     status_ff <= ST_PENDING;
                     state_ff  <= S_DONE;
                  end else begin
                     if (hit_meet) begin
                        ovl_ff <= (ovl_ff == 2'd2) ? 2'd2 : ovl_ff + 2'd1;
                        mg_ff  <= box_union(mg_ff, ent);
                     end
                     if (last) begin
                        state_ff <= S_SELECT;
                     end
                  end
               end
            end
            S_SELECT: begin
               if (ovl_ff == 2'd2) begin
                  r_ff <= mg_ff;
               end
               state_ff <= S_AREA_A;
            end
            S_AREA_A: begin
               area_ff  <= product;
               state_ff <= S_AREA_L;
            end
            S_AREA_L: begin
               larea_ff <= product;
               state_ff <= S_AREA_CMP;
            end
            S_AREA_CMP: begin
               if (big) begin
                  r_ff     <= lay;
                  whole_ff <= 1'b1;
               end
               rd_i_ff  <= '0;
               wr_k_ff  <= '0;
               state_ff <= S_SWEEP;
            end
            S_SWEEP: begin
               if (pend_ff) begin
                  if (keep) begin
                     wr_k_ff <= wr_k_ff + CW'(1);
                  end
                  if (last) begin
                     state_ff <= mark_ff ? S_DONE : S_APPEND;
                  end
               end
            end
            S_APPEND: begin
               res_ff   <= full ? lay : r_ff;
               whole_ff <= whole_ff | full;
               state_ff <= S_DONE;
            end
            S_READ: begin
               res_ff    <= ent;
               status_ff <= ST_DONE;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= status_ff;
                  rsp_ff.entry_count <= 5'(count_ff);
                  rsp_ff.ent         <= res_ff;
                  rsp_ff.whole_layer <= whole_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("Entry count exceeds the list depth.");

   a_whole_append: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.whole_layer) |-> (rsp_ff.status == ST_APPENDED))
      else $error("Whole-layer flag on a transaction that appended nothing.");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_wr_en)
      else $error("Entry store written during the overlap scan.");

endmodule
`default_nettype wire

/* hw/rtl/dirty_rect_pile_manager_core.sv */
// Response time for record and invalidation grows with the number of entries in the list,
// as each entry is read through the single store read port; ignored requests, reads and
// record on an empty list do not scan the list.
// One transaction at a time; the next request is accepted from the cycle after the response
// is registered, even while that response still waits for its taker.
// Synchronous active-high reset empties the list and clears the layer registers.
`timescale 1ns / 1ps
`default_nettype none
module dirty_rect_pile_manager_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_rect_x,
   input  logic [11:0] req_rect_y,
   input  logic [12:0] req_rect_w,
   input  logic [12:0] req_rect_h,
   input  logic [3:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entry_count,
   output logic [11:0] rsp_out_x,
   output logic [11:0] rsp_out_y,
   output logic [12:0] rsp_out_w,
   output logic [12:0] rsp_out_h,
   output logic        rsp_out_recorded,
   output logic        rsp_whole_layer,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import drpm_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [12:0] layer_width_ff;
   logic [12:0] layer_height_ff;
   logic [3:0]  buffer_margin_ff;
   logic        cfg_clear;
   cfg_type     cfg;
   req_type     req;
   rsp_type     rsp;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   box_type       mem_rd_data;
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   box_type       mem_wr_data;

   assign cfg_clear = csr_wr_en && (csr_index inside {CSR_LAYER_WIDTH, CSR_LAYER_HEIGHT,
                                                      CSR_BUFFER_MARGIN});

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_width_ff   <= '0;
         layer_height_ff  <= '0;
         buffer_margin_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LAYER_WIDTH:   layer_width_ff   <= csr_wdata;
            CSR_LAYER_HEIGHT:  layer_height_ff  <= csr_wdata;
            CSR_BUFFER_MARGIN: buffer_margin_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.lay_w  = (layer_width_ff > MAX_DIM) ? MAX_DIM : layer_width_ff;
   assign cfg.lay_h  = (layer_height_ff > MAX_DIM) ? MAX_DIM : layer_height_ff;
   assign cfg.margin = buffer_margin_ff;

   assign req = '{op: req_op, rect_x: req_rect_x, rect_y: req_rect_y, rect_w: req_rect_w,
                  rect_h: req_rect_h, entry_index: req_entry_index};

   assign rsp_status       = rsp.status;
   assign rsp_entry_count  = rsp.entry_count;
   assign rsp_out_x        = rsp.ent.x;
   assign rsp_out_y        = rsp.ent.y;
   assign rsp_out_w        = rsp.ent.w;
   assign rsp_out_h        = rsp.ent.h;
   assign rsp_out_recorded = rsp.ent.rec;
   assign rsp_whole_layer  = rsp.whole_layer;

   drpm_entry_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   drpm_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IW          (IW),
      .CW          (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_clear   (cfg_clear),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule
`default_nettype wire
